### design/tlf_pkg.sv
// shared types and constants of the text line folder
package tlf_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_TAB     = 8'd9;

  localparam logic [5:0] WIDTH_RESET = 6'd10;

  localparam logic KIND_CHAR  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic flush_setup;
    logic scan_setup;
    logic scan_read;
    logic scan_hit;
    logic scan_step;
    logic emit_read;
    logic emit_load;
    logic nl_load;
    logic append;
  } cmd_t;

  typedef struct packed {
    logic end_empty;
    logic is_flush;
    logic over;
    logic pos_zero;
    logic blank;
    logic emit_done;
    logic out_free;
  } status_t;

endpackage

### design/tlf_ctrl.sv
// sequencer of the text line folder
module tlf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  tlf_pkg::status_t sts,
  output tlf_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_NL,
    ST_APPEND
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.end_empty) begin
          state_nxt = ST_IDLE;
        end else if (sts.is_flush) begin
          cmd.flush_setup = 1'b1;
          state_nxt       = ST_EMIT_RD;
        end else if (sts.over) begin
          cmd.scan_setup = 1'b1;
          state_nxt      = ST_SCAN_RD;
        end else begin
          state_nxt = ST_APPEND;
        end
      end
      ST_SCAN_RD: begin
        // first column is never a fold point
        if (sts.pos_zero) begin
          state_nxt = ST_EMIT_RD;
        end else begin
          cmd.scan_read = 1'b1;
          state_nxt     = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (sts.blank) begin
          cmd.scan_hit = 1'b1;
          state_nxt    = ST_EMIT_RD;
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt     = ST_SCAN_RD;
        end
      end
      ST_EMIT_RD: begin
        if (sts.emit_done) begin
          state_nxt = ST_NL;
        end else begin
          cmd.emit_read = 1'b1;
          state_nxt     = ST_EMIT_WR;
        end
      end
      ST_EMIT_WR: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          state_nxt     = ST_EMIT_RD;
        end
      end
      ST_NL: begin
        if (sts.out_free) begin
          cmd.nl_load = 1'b1;
          state_nxt   = sts.is_flush ? ST_IDLE : ST_APPEND;
        end
      end
      ST_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### design/tlf_datapath.sv
// segment memory, counters and output register of the text line folder
module tlf_datapath #(
  parameter int unsigned DEPTH = tlf_pkg::DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tlf_pkg::in_item_t   in_item,
  input  logic                cfg_we,
  input  logic [5:0]          cfg_wdata,
  output logic                out_valid,
  input  logic                out_stall,
  output tlf_pkg::out_item_t  out_item,
  input  tlf_pkg::cmd_t       cmd,
  output tlf_pkg::status_t    sts
);

  localparam int unsigned HW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [7:0] mem [DEPTH];

  logic [5:0]  line_width_r;
  logic [CW-1:0] count_r;
  logic [HW-1:0] head_r;
  logic [CW-1:0] pos_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] emit_n_r;
  logic          flush_r;
  tlf_pkg::in_item_t  item_r;
  logic [7:0]    rd_data_r;
  logic          out_valid_r;
  tlf_pkg::out_item_t out_item_r;

  logic [CW-1:0] w_eff;
  logic [CW-1:0] ring_off;
  logic [CW:0]   ring_sum;
  logic [HW-1:0] ring_idx;
  logic          out_free;

  // effective width: zero acts as one, capped at the buffer depth
  always_comb begin
    if (line_width_r == 6'd0) begin
      w_eff = CW'(1);
    end else if (int'(line_width_r) > int'(DEPTH)) begin
      w_eff = CW'(DEPTH);
    end else begin
      w_eff = CW'(line_width_r);
    end
  end

  // ring index of head plus an offset, sum stays below twice the depth
  always_comb begin
    if (cmd.scan_read) begin
      ring_off = pos_r;
    end else if (cmd.nl_load) begin
      ring_off = emit_n_r;
    end else if (cmd.append) begin
      ring_off = count_r;
    end else begin
      ring_off = idx_r;
    end
    ring_sum = (CW+1)'(head_r) + (CW+1)'(ring_off);
    if (int'(ring_sum) >= int'(DEPTH)) begin
      ring_idx = HW'(ring_sum - (CW+1)'(DEPTH));
    end else begin
      ring_idx = HW'(ring_sum);
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign sts.end_empty = (item_r.kind == tlf_pkg::KIND_FLUSH) && (count_r == '0);
  assign sts.is_flush  = (item_r.kind == tlf_pkg::KIND_FLUSH) ||
                         (item_r.char_in == tlf_pkg::CH_NEWLINE);
  assign sts.over      = (count_r >= w_eff);
  assign sts.pos_zero  = (pos_r == '0);
  assign sts.blank     = (rd_data_r == tlf_pkg::CH_SPACE) ||
                         (rd_data_r == tlf_pkg::CH_TAB);
  assign sts.emit_done = (idx_r == emit_n_r);
  assign sts.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[ring_idx] <= item_r.char_in;
    end
    if (cmd.scan_read || cmd.emit_read) begin
      rd_data_r <= mem[ring_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
    if (cmd.flush_setup) begin
      emit_n_r <= count_r;
    end else if (cmd.scan_setup) begin
      emit_n_r <= w_eff;
    end else if (cmd.scan_hit) begin
      emit_n_r <= pos_r + CW'(1);
    end
    if (cmd.scan_setup) begin
      pos_r <= w_eff - CW'(1);
    end else if (cmd.scan_step) begin
      pos_r <= pos_r - CW'(1);
    end
    if (cmd.flush_setup || cmd.scan_setup) begin
      idx_r <= '0;
    end else if (cmd.emit_load) begin
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.emit_load) begin
      out_item_r.char_out <= rd_data_r;
      out_item_r.last     <= 1'b0;
    end else if (cmd.nl_load) begin
      out_item_r.char_out <= tlf_pkg::CH_NEWLINE;
      out_item_r.last     <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= tlf_pkg::WIDTH_RESET;
      count_r      <= '0;
      head_r       <= '0;
      flush_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        line_width_r <= cfg_wdata;
      end
      if (cmd.capture) begin
        flush_r <= 1'b0;
      end else if (cmd.flush_setup) begin
        flush_r <= 1'b1;
      end
      if (cmd.nl_load) begin
        if (flush_r) begin
          count_r <= '0;
          head_r  <= '0;
        end else begin
          count_r <= count_r - emit_n_r;
          head_r  <= ring_idx;
        end
      end else if (cmd.append) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.emit_load || cmd.nl_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= int'(DEPTH))
    else $error("segment count above buffer depth");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_load || cmd.nl_load) |-> out_free)
    else $error("output register overwritten while a request waits");

  a_append_inc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |=> count_r == $past(count_r) + CW'(1))
    else $error("append did not grow the segment");

  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load |-> idx_r < emit_n_r)
    else $error("emit past the cut");

  a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.nl_load && flush_r) |=> count_r == '0)
    else $error("flush left characters held");
`endif

endmodule

### design/text_line_folder.sv
// top level of the text line folder
// Folds a byte stream so no output line exceeds line_width characters (0 acts
// as 1, widths above DEPTH act as DEPTH). A plain character that fits is only
// buffered, via the decide and append states. A fold scans back from the last
// column, with a read and a check state per column examined, then emits the
// cut, a read and a write state per byte, plus the newline, then buffers the
// new character; a newline or end-of-input request emits the held bytes the
// same way. The split steps come from the single read port of the segment
// memory with its registered read data. Each newline the block inserts
// carries last. End of input with nothing held produces no output request.
module text_line_folder #(
  parameter int unsigned DEPTH = tlf_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tlf_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output tlf_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [5:0]         cfg_wdata
);

  tlf_pkg::cmd_t    cmd;
  tlf_pkg::status_t sts;

  tlf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tlf_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
